[rtl/core/rfa_pkg.sv]
`timescale 1ns / 1ps

package rfa_pkg;

	typedef enum logic [1:0] {
		CMD_ADD = 2'd0,
		CMD_SUB = 2'd1,
		CMD_MUL = 2'd2,
		CMD_DIV = 2'd3
	} cmd_t;

	localparam int unsigned CMD_W       = 2;
	localparam int unsigned RES_NUM_W   = 33;
	localparam int unsigned RES_DEN_W   = 31;
	localparam int unsigned OUT_TDATA_W = ((RES_NUM_W + RES_DEN_W + 7) / 8) * 8;

endpackage

[rtl/core/rational_fraction_alu.sv]
`timescale 1ns / 1ps

// channel  dir  tdata fields, lowest bit up                          tuser
// s_*      in   cmd, num_a, den_a, num_b, den_b (OPERAND_WIDTH each)  -
// m_*      out  res_num (33), res_den (31)                            undefined
//
// one item at a time: the shared multiplier forms the products in S_MUL0 and S_MUL2,
// with S_MUL1 between them for add and subtract, then S_COMB combines them, then a binary
// gcd (one shift or subtract a cycle), then restoring division of both parts by the odd
// gcd factor, and S_FIN loads the output register; zero parts skip the gcd and
// division
// reset clears the sequencer and the output valid; s_tready is high only when idle
// a result waiting on m_tready holds the block in S_FIN until taken
module rational_fraction_alu #(
	parameter int unsigned OPERAND_WIDTH = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// cmd, num_a, den_a, num_b, den_b, zero fill
	input  logic [((rfa_pkg::CMD_W + 4 * OPERAND_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,
	output logic m_tvalid,
	input  logic m_tready,
	// res_num, res_den
	output logic [rfa_pkg::OUT_TDATA_W - 1:0] m_tdata,
	// undefined
	output logic m_tuser
);

	localparam int unsigned W  = OPERAND_WIDTH;
	localparam int unsigned MW = 2 * W;
	localparam int unsigned CW = $clog2(MW);
	localparam int unsigned NW = rfa_pkg::RES_NUM_W;
	localparam int unsigned DW = rfa_pkg::RES_DEN_W;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL0,
		S_MUL1,
		S_MUL2,
		S_COMB,
		S_GCD,
		S_DIV,
		S_FIN
	} state_t;

	state_t state_q;

	rfa_pkg::cmd_t cmd_q;
	logic [W-1:0]  na_q, da_q, nb_q, db_q;
	logic          na_neg_q, da_neg_q, nb_neg_q, db_neg_q;
	logic [MW-1:0] x_q, y_q, n_q, d_q, u_q, v_q, rn_q, rd_q;
	logic          neg_q;
	logic [CW-1:0] cnt_q;

	function automatic logic [W-1:0] mag_of(input logic [W-1:0] v);
		mag_of = v[W-1] ? (~v + W'(1)) : v;
	endfunction

	logic [W-1:0] in_num_a, in_den_a, in_num_b, in_den_b;
	assign in_num_a = s_tdata[rfa_pkg::CMD_W +: W];
	assign in_den_a = s_tdata[rfa_pkg::CMD_W + W +: W];
	assign in_num_b = s_tdata[rfa_pkg::CMD_W + 2 * W +: W];
	assign in_den_b = s_tdata[rfa_pkg::CMD_W + 3 * W +: W];

	assign s_tready = (state_q == S_IDLE);

	// shared multiplier
	logic [W-1:0]  mul_a, mul_b;
	logic [MW-1:0] mul_p;
	always_comb begin
		case (state_q)
			S_MUL0: begin
				mul_a = na_q;
				mul_b = (cmd_q == rfa_pkg::CMD_MUL) ? nb_q : db_q;
			end
			S_MUL1: begin
				mul_a = nb_q;
				mul_b = da_q;
			end
			default: begin
				mul_a = da_q;
				mul_b = (cmd_q == rfa_pkg::CMD_DIV) ? nb_q : db_q;
			end
		endcase
	end
	assign mul_p = mul_a * mul_b;

	// signs of the products, zero magnitudes carry no sign
	logic          x_neg, y_neg, b_neg, dn_neg, n_neg, is_addsub;
	logic [MW-1:0] n_mag;
	assign x_neg  = (na_neg_q ^ ((cmd_q == rfa_pkg::CMD_MUL) ? nb_neg_q : db_neg_q))
		&& (x_q != '0);
	assign y_neg  = (nb_neg_q ^ da_neg_q) && (y_q != '0);
	assign b_neg  = (cmd_q == rfa_pkg::CMD_SUB) ? !y_neg : y_neg;
	assign dn_neg = (da_neg_q ^ ((cmd_q == rfa_pkg::CMD_DIV) ? nb_neg_q : db_neg_q))
		&& (d_q != '0);
	assign is_addsub = (cmd_q == rfa_pkg::CMD_ADD) || (cmd_q == rfa_pkg::CMD_SUB);

	always_comb begin
		logic nn;
		nn = x_neg;
		n_mag = x_q;
		if (is_addsub) begin
			if (x_neg == b_neg) begin
				n_mag = x_q + y_q;
			end else if (x_q >= y_q) begin
				n_mag = x_q - y_q;
			end else begin
				n_mag = y_q - x_q;
				nn = b_neg;
			end
		end
		n_neg = nn && (n_mag != '0);
	end

	logic gcd_done;
	assign gcd_done = u_q[0] && v_q[0] && (u_q == v_q);

	// one restoring division step on both parts
	logic [MW:0] tn, td;
	logic        qn_bit, qd_bit;
	assign tn = {rn_q, n_q[MW-1]};
	assign td = {rd_q, d_q[MW-1]};
	assign qn_bit = (tn >= {1'b0, u_q});
	assign qd_bit = (td >= {1'b0, u_q});

	// result fields, wrapped to the output widths
	logic [MW+NW-1:0] num_wide;
	logic [MW+DW-1:0] den_wide;
	logic [NW-1:0]    num_lo, num_res;
	assign num_wide = {{NW{1'b0}}, n_q};
	assign den_wide = {{DW{1'b0}}, d_q};
	assign num_lo   = num_wide[NW-1:0];
	assign num_res  = neg_q ? (~num_lo + NW'(1)) : num_lo;

	logic out_free;
	assign out_free = !m_tvalid || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			m_tvalid <= 1'b0;
			m_tdata  <= '0;
			m_tuser  <= 1'b0;
			cnt_q    <= '0;
		end else begin
			// the final state reloads the output itself
			if (m_tvalid && m_tready && (state_q != S_FIN)) begin
				m_tvalid <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						state_q <= S_MUL0;
					end
				end
				S_MUL0: begin
					state_q <= is_addsub ? S_MUL1 : S_MUL2;
				end
				S_MUL1: begin
					state_q <= S_MUL2;
				end
				S_MUL2: begin
					state_q <= S_COMB;
				end
				S_COMB: begin
					state_q <= ((n_mag == '0) || (d_q == '0)) ? S_FIN : S_GCD;
				end
				S_GCD: begin
					if (gcd_done) begin
						state_q <= S_DIV;
						cnt_q   <= CW'(MW - 1);
					end
				end
				S_DIV: begin
					cnt_q <= cnt_q - CW'(1);
					if (cnt_q == '0) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (out_free) begin
						m_tvalid <= 1'b1;
						m_tdata  <= {den_wide[DW-1:0], num_res};
						m_tuser  <= (d_q == '0);
						state_q  <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					cmd_q    <= rfa_pkg::cmd_t'(s_tdata[rfa_pkg::CMD_W-1:0]);
					na_q     <= mag_of(in_num_a);
					da_q     <= mag_of(in_den_a);
					nb_q     <= mag_of(in_num_b);
					db_q     <= mag_of(in_den_b);
					na_neg_q <= in_num_a[W-1];
					da_neg_q <= in_den_a[W-1];
					nb_neg_q <= in_num_b[W-1];
					db_neg_q <= in_den_b[W-1];
				end
			end
			S_MUL0: begin
				x_q <= mul_p;
			end
			S_MUL1: begin
				y_q <= mul_p;
			end
			S_MUL2: begin
				d_q <= mul_p;
			end
			S_COMB: begin
				n_q   <= n_mag;
				neg_q <= (n_neg != dn_neg) && (n_mag != '0);
				u_q   <= n_mag;
				v_q   <= d_q;
			end
			S_GCD: begin
				// common factors of two come straight off both parts
				if (!u_q[0] && !v_q[0]) begin
					u_q <= u_q >> 1;
					v_q <= v_q >> 1;
					n_q <= n_q >> 1;
					d_q <= d_q >> 1;
				end else if (!u_q[0]) begin
					u_q <= u_q >> 1;
				end else if (!v_q[0]) begin
					v_q <= v_q >> 1;
				end else if (u_q > v_q) begin
					u_q <= u_q - v_q;
				end else if (v_q > u_q) begin
					v_q <= v_q - u_q;
				end
				if (gcd_done) begin
					rn_q <= '0;
					rd_q <= '0;
				end
			end
			S_DIV: begin
				rn_q <= qn_bit ? MW'(tn - {1'b0, u_q}) : tn[MW-1:0];
				rd_q <= qd_bit ? MW'(td - {1'b0, u_q}) : td[MW-1:0];
				n_q  <= {n_q[MW-2:0], qn_bit};
				d_q  <= {d_q[MW-2:0], qd_bit};
			end
			default: begin
			end
		endcase
	end

endmodule

[sim/rfa_result_checker.sv]
`timescale 1ns / 1ps

module rfa_result_checker #(
	parameter int unsigned OPERAND_WIDTH = 16,
	parameter int unsigned IN_W = ((rfa_pkg::CMD_W + 4 * OPERAND_WIDTH + 7) / 8) * 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	input  logic                              s_tready,
	input  logic [IN_W - 1:0]                 s_tdata,
	input  logic                              m_tvalid,
	input  logic                              m_tready,
	input  logic [rfa_pkg::OUT_TDATA_W - 1:0] m_tdata,
	input  logic                              m_tuser,
	output int                                fail_count,
	output int                                pending
);

	typedef struct packed {
		logic [rfa_pkg::RES_NUM_W - 1:0] num;
		logic [rfa_pkg::RES_DEN_W - 1:0] den;
		logic                            is_undefined;
	} fraction_t;

	fraction_t fraction_q[$];
	fraction_t oldest;
	int        fails = 0;
	int        waiting = 0;

	assign fail_count = fails;
	assign pending    = waiting;

	function automatic longint unsigned common_divisor(longint unsigned x, longint unsigned y);
		longint unsigned t;
		while (y != 0) begin
			t = x % y;
			x = y;
			y = t;
		end
		return x;
	endfunction

	function automatic fraction_t reduce_fraction(logic [IN_W - 1:0] item);
		rfa_pkg::cmd_t                      op;
		logic signed [OPERAND_WIDTH - 1:0]  na, da, nb, db;
		longint                             n, d, r;
		longint unsigned                    nm, dm, g;
		logic                               neg;
		fraction_t                          f;
		op = rfa_pkg::cmd_t'(item[rfa_pkg::CMD_W - 1:0]);
		na = item[rfa_pkg::CMD_W + 0 * OPERAND_WIDTH +: OPERAND_WIDTH];
		da = item[rfa_pkg::CMD_W + 1 * OPERAND_WIDTH +: OPERAND_WIDTH];
		nb = item[rfa_pkg::CMD_W + 2 * OPERAND_WIDTH +: OPERAND_WIDTH];
		db = item[rfa_pkg::CMD_W + 3 * OPERAND_WIDTH +: OPERAND_WIDTH];
		case (op)
			rfa_pkg::CMD_ADD: begin
				n = longint'(na) * longint'(db) + longint'(nb) * longint'(da);
				d = longint'(da) * longint'(db);
			end
			rfa_pkg::CMD_SUB: begin
				n = longint'(na) * longint'(db) - longint'(nb) * longint'(da);
				d = longint'(da) * longint'(db);
			end
			rfa_pkg::CMD_MUL: begin
				n = longint'(na) * longint'(nb);
				d = longint'(da) * longint'(db);
			end
			default: begin
				n = longint'(na) * longint'(db);
				d = longint'(da) * longint'(nb);
			end
		endcase
		neg = ((n < 0) != (d < 0)) && (n != 0);
		nm  = (n < 0) ? longint'(-n) : longint'(n);
		dm  = (d < 0) ? longint'(-d) : longint'(d);
		// zero on either side leaves the fraction unreduced
		g = (nm != 0 && dm != 0) ? common_divisor(nm, dm) : 64'd1;
		nm = nm / g;
		dm = dm / g;
		r = neg ? -longint'(nm) : longint'(nm);
		f.num          = r[rfa_pkg::RES_NUM_W - 1:0];
		f.den          = dm[rfa_pkg::RES_DEN_W - 1:0];
		f.is_undefined = (dm == 0);
		return f;
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				fraction_q.push_back(reduce_fraction(s_tdata));
			if (m_tvalid && m_tready) begin
				if (fraction_q.size() == 0) begin
					$error("result item with no input item pending");
					fails++;
				end else begin
					oldest = fraction_q.pop_front();
					if (m_tdata[rfa_pkg::RES_NUM_W - 1:0] !== oldest.num) begin
						$error("res_num: expected %0d, actual %0d", $signed(oldest.num),
							$signed(m_tdata[rfa_pkg::RES_NUM_W - 1:0]));
						fails++;
					end
					if (m_tdata[rfa_pkg::RES_NUM_W +: rfa_pkg::RES_DEN_W] !== oldest.den) begin
						$error("res_den: expected %0d, actual %0d", oldest.den,
							m_tdata[rfa_pkg::RES_NUM_W +: rfa_pkg::RES_DEN_W]);
						fails++;
					end
					if (m_tuser !== oldest.is_undefined) begin
						$error("undefined: expected %0b, actual %0b", oldest.is_undefined,
							m_tuser);
						fails++;
					end
				end
			end
			waiting <= fraction_q.size();
		end
	end

endmodule

[sim/tb_rational_fraction_alu.sv]
`timescale 1ns / 1ps

module tb_rational_fraction_alu;

	localparam int unsigned OPW = 16;
	localparam int unsigned IN_W = ((rfa_pkg::CMD_W + 4 * OPW + 7) / 8) * 8;
	localparam int RANDOM_ITEMS = 680;
	localparam int CALM_ITEMS = 100;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int DRAIN_CYCLES = 300;
	localparam logic [OPW - 1:0] MOST_NEG = 16'h8000;
	localparam logic [OPW - 1:0] MOST_POS = 16'h7fff;

	logic                              clk = 1'b0;
	logic                              arst_n = 1'b0;
	logic                              s_tvalid = 1'b0;
	logic                              s_tready;
	logic [IN_W - 1:0]                 s_tdata = '0;
	logic                              m_tvalid;
	logic                              m_tready = 1'b0;
	logic [rfa_pkg::OUT_TDATA_W - 1:0] m_tdata;
	logic                              m_tuser;

	int fail_count;
	int pending;
	bit idle_on = 1'b1;
	int stall_left = 0;
	int cycles = 0;

	always #5 clk = ~clk;

	rational_fraction_alu #(
		.OPERAND_WIDTH(OPW)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	rfa_result_checker #(
		.OPERAND_WIDTH(OPW)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.fail_count(fail_count),
		.pending(pending)
	);

	// receiver stalls in bursts of random length
	always @(posedge clk) begin
		if (stall_left > 0) begin
			m_tready   <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (idle_on && $urandom_range(0, 9) == 0) begin
			m_tready   <= 1'b0;
			stall_left <= $urandom_range(0, 17);
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	task automatic send_fraction(input rfa_pkg::cmd_t op, input logic [OPW - 1:0] na,
		input logic [OPW - 1:0] da, input logic [OPW - 1:0] nb, input logic [OPW - 1:0] db);
		int gap;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 18);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {{(IN_W - rfa_pkg::CMD_W - 4 * OPW){1'b0}}, db, nb, da, na, op};
		do @(posedge clk); while (!s_tready);
	endtask

	function automatic logic [OPW - 1:0] pick_operand();
		logic [OPW - 1:0] v;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: v = OPW'($urandom);
			4, 5, 6, 7: v = OPW'($urandom_range(0, 40)) - OPW'(20);
			8: begin
				case ($urandom_range(0, 3))
					0: v = MOST_NEG;
					1: v = MOST_POS;
					2: v = '1;
					default: v = OPW'(1);
				endcase
			end
			default: v = '0;
		endcase
		return v;
	endfunction

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		send_fraction(rfa_pkg::CMD_ADD, 1, 2, 1, 3);
		send_fraction(rfa_pkg::CMD_SUB, 1, 2, 1, 2);
		send_fraction(rfa_pkg::CMD_MUL, -3, 4, 2, -5);
		send_fraction(rfa_pkg::CMD_DIV, 6, 8, 3, 4);
		send_fraction(rfa_pkg::CMD_ADD, 0, 5, 0, -7);
		send_fraction(rfa_pkg::CMD_SUB, MOST_POS, MOST_NEG, MOST_NEG, MOST_POS);
		send_fraction(rfa_pkg::CMD_MUL, MOST_NEG, MOST_NEG, MOST_NEG, MOST_NEG);
		send_fraction(rfa_pkg::CMD_DIV, MOST_NEG, 1, 1, MOST_NEG);
		send_fraction(rfa_pkg::CMD_ADD, MOST_NEG, MOST_NEG, MOST_NEG, MOST_NEG);
		send_fraction(rfa_pkg::CMD_ADD, MOST_NEG, 1, MOST_NEG, 1);
		send_fraction(rfa_pkg::CMD_SUB, MOST_POS, 1, MOST_NEG, 1);
		send_fraction(rfa_pkg::CMD_ADD, MOST_POS, MOST_POS, MOST_POS, MOST_POS);
		// zero denominators on every operation
		send_fraction(rfa_pkg::CMD_ADD, 5, 0, 2, 3);
		send_fraction(rfa_pkg::CMD_SUB, -5, 0, 7, 0);
		send_fraction(rfa_pkg::CMD_MUL, 3, 0, 0, 0);
		send_fraction(rfa_pkg::CMD_DIV, 7, 3, 0, 5);
		send_fraction(rfa_pkg::CMD_DIV, 0, 3, 0, 5);
		// sign lands on the numerator
		send_fraction(rfa_pkg::CMD_MUL, 1, -1, 1, 1);
		send_fraction(rfa_pkg::CMD_DIV, 1, -1, -1, 1);
		send_fraction(rfa_pkg::CMD_MUL, -1, -1, -1, -1);
		send_fraction(rfa_pkg::CMD_SUB, 0, -9, 0, 4);
		send_fraction(rfa_pkg::CMD_DIV, -12, 0, 4, 6);

		// hold off until the pipeline is empty
		wait_drained();

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == RANDOM_ITEMS - CALM_ITEMS)
				idle_on <= 1'b0;
			else if (i % 50 == 0 && i < RANDOM_ITEMS - CALM_ITEMS)
				idle_on <= ($urandom_range(0, 3) != 0);
			send_fraction(rfa_pkg::cmd_t'($urandom_range(0, 3)), pick_operand(),
				pick_operand(), pick_operand(), pick_operand());
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
